// ===== hdl/asp_pkg.sv =====
`default_nettype none
package asp_pkg;

    localparam int NODE_W    = 16;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int CNT_W     = NODE_W + 1;
    localparam int EDGE_AW   = 19;
    localparam int MAX_EDGES = 1 << EDGE_AW;
    localparam int LINK_W    = EDGE_AW + 1;
    localparam int WGT_W     = 16;
    localparam int CRD_W     = 16;
    localparam int COST_W    = 30;
    localparam int CAND_W    = COST_W + 1;
    localparam int KEY_W     = 32;
    localparam int H_W       = 20;
    localparam int DIAG_STEP     = 14;
    localparam int STRAIGHT_STEP = 10;

    localparam logic [COST_W-1:0] COST_SENT = COST_W'(999999999);

    localparam logic [1:0] REQ_COORD = 2'd0;
    localparam logic [1:0] REQ_EDGE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [NODE_W-1:0] node_id;
        logic [CRD_W-1:0]  coord_x;
        logic [CRD_W-1:0]  coord_y;
        logic [NODE_W-1:0] edge_target;
        logic [WGT_W-1:0]  edge_weight;
        logic [NODE_W-1:0] goal_node;
    } t_req;

    typedef struct packed {
        logic [COST_W-1:0] path_cost;
        logic              reached;
    } t_resp;

    typedef struct packed {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [NODE_W-1:0] target;
        logic [WGT_W-1:0]  weight;
        logic [LINK_W-1:0] next;
    } t_arc;

    typedef struct packed {
        logic [NODE_W-1:0] vertex;
        logic [KEY_W-1:0]  key;
    } t_slot;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_EDGE_WR,
        ST_Q_RD, ST_Q_RS, ST_Q_HS, ST_Q_HL, ST_INIT,
        ST_POP, ST_POP_U, ST_POP_G, ST_POP_L,
        ST_SD_L, ST_SD_R, ST_SD_CMP, ST_SD_FIN,
        ST_ED_HEAD, ST_ED_CHK, ST_ED_ARC, ST_ED_POS, ST_ED_COST, ST_ED_H1, ST_ED_H2,
        ST_SU, ST_SU_CMP, ST_SU_FIN,
        ST_FIN_RD, ST_FIN, ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/astar_graph_shortest_path.sv =====
`default_nettype none
// A* shortest-path engine over a loaded directed graph with an octile heuristic. After reset
// the edge-list heads are swept clear, one node a cycle, during which no word is accepted.
// A coordinate load is written as it is accepted; an edge load reads the node's list head,
// then writes the new arc and head. A query rebuilds the cost, heap and position memories,
// then extracts nodes with a sift-down each and scans their edges with a sift-up for each
// improved cost; its pace is set by the single read port of each memory, with every heap
// move a read followed by a write-back.
module astar_graph_shortest_path (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire asp_pkg::t_req i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output asp_pkg::t_resp     o_data
);
    import asp_pkg::*;

    localparam logic [KEY_W-1:0] KEY_SENT = KEY_W'(COST_SENT);

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_clr, n_clr;
    logic [LINK_W-1:0]   r_ec, n_ec;
    logic [CNT_W-1:0]    r_nt, n_nt;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    t_req                r_req, n_req;
    t_point              r_cdst, n_cdst;
    logic [NODE_W-1:0]   r_v, n_v;
    logic [NODE_W-1:0]   r_u, n_u;
    logic [COST_W-1:0]   r_gu, n_gu;
    logic [NODE_W-1:0]   r_ev, n_ev;
    logic [KEY_W-1:0]    r_ek, n_ek;
    logic [NODE_W-1:0]   r_i, n_i;
    t_slot               r_lslot, n_lslot;
    logic                r_rok, n_rok;
    logic [LINK_W-1:0]   r_link, n_link;
    logic [NODE_W-1:0]   r_w, n_w;
    logic [CAND_W-1:0]   r_cand, n_cand;
    logic [CNT_W-1:0]    r_pi, n_pi;
    logic [COST_W-1:0]   r_cost, n_cost;
    logic                r_ovalid, n_ovalid;
    t_resp               r_odata, n_odata;

    logic                crd_we, crd_re;
    logic [NODE_W-1:0]   crd_wa, crd_ra;
    t_point              crd_wd, crd_q;
    logic                hd_we, hd_re;
    logic [NODE_W-1:0]   hd_wa, hd_ra;
    logic [LINK_W-1:0]   hd_wd, hd_q;
    logic                eg_we, eg_re;
    logic [EDGE_AW-1:0]  eg_wa, eg_ra;
    t_arc                eg_wd, eg_q;
    logic                cs_we, cs_re;
    logic [NODE_W-1:0]   cs_wa, cs_ra;
    logic [COST_W-1:0]   cs_wd, cs_q;
    logic                hp_we, hp_re;
    logic [NODE_W-1:0]   hp_wa, hp_ra;
    t_slot               hp_wd, hp_q;
    logic                ps_we, ps_re;
    logic [NODE_W-1:0]   ps_wa, ps_ra;
    logic [CNT_W-1:0]    ps_wd, ps_q;
    logic [H_W-1:0]      oct_h;

    logic                accept;
    logic                out_free;
    logic [CNT_W-1:0]    idx_l, idx_r, id_p1, to_p1, nt_max;
    logic [NODE_W-1:0]   idx_p;
    logic [1:0]          sel;
    logic [KEY_W-1:0]    best_k;

    asp_ram #(.DW($bits(t_point)), .AW(NODE_W)) u_coord (
        .i_clk(i_clk), .i_we(crd_we), .i_waddr(crd_wa), .i_wdata(crd_wd),
        .i_re(crd_re), .i_raddr(crd_ra), .o_rdata(crd_q));
    asp_ram #(.DW(LINK_W), .AW(NODE_W)) u_heads (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_re(hd_re), .i_raddr(hd_ra), .o_rdata(hd_q));
    asp_ram #(.DW($bits(t_arc)), .AW(EDGE_AW)) u_edges (
        .i_clk(i_clk), .i_we(eg_we), .i_waddr(eg_wa), .i_wdata(eg_wd),
        .i_re(eg_re), .i_raddr(eg_ra), .o_rdata(eg_q));
    asp_ram #(.DW(COST_W), .AW(NODE_W)) u_cost (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_wa), .i_wdata(cs_wd),
        .i_re(cs_re), .i_raddr(cs_ra), .o_rdata(cs_q));
    asp_ram #(.DW($bits(t_slot)), .AW(NODE_W)) u_heap (
        .i_clk(i_clk), .i_we(hp_we), .i_waddr(hp_wa), .i_wdata(hp_wd),
        .i_re(hp_re), .i_raddr(hp_ra), .o_rdata(hp_q));
    asp_ram #(.DW(CNT_W), .AW(NODE_W)) u_pos (
        .i_clk(i_clk), .i_we(ps_we), .i_waddr(ps_wa), .i_wdata(ps_wd),
        .i_re(ps_re), .i_raddr(ps_ra), .o_rdata(ps_q));

    asp_octile u_oct (.i_clk(i_clk), .i_a(crd_q), .i_b(r_cdst), .o_h(oct_h));

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ec     <= '0;
            r_nt     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ec     <= n_ec;
            r_nt     <= n_nt;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_cdst  <= n_cdst;
        r_v     <= n_v;
        r_u     <= n_u;
        r_gu    <= n_gu;
        r_ev    <= n_ev;
        r_ek    <= n_ek;
        r_i     <= n_i;
        r_lslot <= n_lslot;
        r_rok   <= n_rok;
        r_link  <= n_link;
        r_w     <= n_w;
        r_cand  <= n_cand;
        r_pi    <= n_pi;
        r_cost  <= n_cost;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state = r_state;  n_clr = r_clr;   n_ec = r_ec;     n_nt = r_nt;
        n_cnt = r_cnt;      n_req = r_req;   n_cdst = r_cdst; n_v = r_v;
        n_u = r_u;          n_gu = r_gu;     n_ev = r_ev;     n_ek = r_ek;
        n_i = r_i;          n_lslot = r_lslot; n_rok = r_rok; n_link = r_link;
        n_w = r_w;          n_cand = r_cand; n_pi = r_pi;     n_cost = r_cost;
        n_ovalid = r_ovalid; n_odata = r_odata;

        crd_we = 1'b0; crd_wa = i_data.node_id; crd_wd = '{x: i_data.coord_x, y: i_data.coord_y};
        crd_re = 1'b0; crd_ra = r_req.goal_node;
        hd_we = 1'b0;  hd_wa = r_clr; hd_wd = '0;
        hd_re = 1'b0;  hd_ra = i_data.node_id;
        eg_we = 1'b0;  eg_wa = r_ec[EDGE_AW-1:0];
        eg_wd = '{target: r_req.edge_target, weight: r_req.edge_weight, next: hd_q};
        eg_re = 1'b0;  eg_ra = r_link[EDGE_AW-1:0] - EDGE_AW'(1);
        cs_we = 1'b0;  cs_wa = r_v; cs_wd = COST_SENT;
        cs_re = 1'b0;  cs_ra = r_u;
        hp_we = 1'b0;  hp_wa = r_i; hp_wd = '{vertex: r_ev, key: r_ek};
        hp_re = 1'b0;  hp_ra = '0;
        ps_we = 1'b0;  ps_wa = r_ev; ps_wd = CNT_W'(r_i);
        ps_re = 1'b0;  ps_ra = r_w;

        idx_l  = {r_i, 1'b1};
        idx_r  = CNT_W'({r_i, 1'b0}) + CNT_W'(2);
        idx_p  = NODE_W'((CNT_W'(r_i) - CNT_W'(1)) >> 1);
        id_p1  = CNT_W'(r_req.node_id) + CNT_W'(1);
        to_p1  = CNT_W'(r_req.edge_target) + CNT_W'(1);
        nt_max = r_nt;
        if (id_p1 > nt_max) nt_max = id_p1;
        if (to_p1 > nt_max) nt_max = to_p1;
        sel    = 2'd0;
        best_k = r_ek;
        if (r_lslot.key < best_k) begin
            sel    = 2'd1;
            best_k = r_lslot.key;
        end
        if (r_rok && hp_q.key < best_k) sel = 2'd2;

        if (r_ovalid && !i_stall) n_ovalid = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                hd_we = 1'b1;
                n_clr = r_clr + NODE_W'(1);
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_req = i_data;
                    unique case (i_data.req_type)
                        REQ_COORD: crd_we = 1'b1;
                        REQ_EDGE: begin
                            if (r_ec < LINK_W'(MAX_EDGES)) begin
                                hd_re   = 1'b1;
                                n_state = ST_EDGE_WR;
                            end
                        end
                        REQ_QUERY: begin
                            if (CNT_W'(i_data.node_id) < r_nt &&
                                CNT_W'(i_data.goal_node) < r_nt) begin
                                n_state = ST_Q_RD;
                            end else begin
                                n_cost  = COST_SENT;
                                n_state = ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EDGE_WR: begin
                eg_we   = 1'b1;
                hd_we   = 1'b1;
                hd_wa   = r_req.node_id;
                hd_wd   = r_ec + LINK_W'(1);
                n_ec    = r_ec + LINK_W'(1);
                n_nt    = nt_max;
                n_state = ST_IDLE;
            end
            ST_Q_RD: begin
                crd_re  = 1'b1;
                n_state = ST_Q_RS;
            end
            ST_Q_RS: begin
                n_cdst  = crd_q;
                crd_re  = 1'b1;
                crd_ra  = r_req.node_id;
                n_state = ST_Q_HS;
            end
            ST_Q_HS: n_state = ST_Q_HL;
            ST_Q_HL: begin
                n_ek    = KEY_W'(oct_h);
                n_cnt   = r_nt;
                n_v     = '0;
                n_state = ST_INIT;
            end
            ST_INIT: begin
                // Slot 0 takes the source and the source's slot takes node 0,
                // which is the swap the seeded heap needs; no sift follows since
                // every other key is the sentinel.
                cs_we = 1'b1;
                hp_we = 1'b1;
                ps_we = 1'b1;
                cs_wa = r_v;
                hp_wa = r_v;
                ps_wa = r_v;
                cs_wd = (r_v == r_req.node_id) ? '0 : COST_SENT;
                if (r_v == '0) begin
                    hp_wd = '{vertex: r_req.node_id, key: r_ek};
                    ps_wd = CNT_W'(r_req.node_id);
                end else if (r_v == r_req.node_id) begin
                    hp_wd = '{vertex: '0, key: KEY_SENT};
                    ps_wd = '0;
                end else begin
                    hp_wd = '{vertex: r_v, key: KEY_SENT};
                    ps_wd = CNT_W'(r_v);
                end
                n_v = r_v + NODE_W'(1);
                if (CNT_W'(r_v) == r_nt - CNT_W'(1)) n_state = ST_POP;
            end
            ST_POP: begin
                if (r_cnt == '0) begin
                    n_state = ST_FIN_RD;
                end else begin
                    hp_re   = 1'b1;
                    n_state = ST_POP_U;
                end
            end
            ST_POP_U: begin
                n_u = hp_q.vertex;
                if (hp_q.vertex == r_req.goal_node) begin
                    n_state = ST_FIN_RD;
                end else begin
                    cs_re   = 1'b1;
                    cs_ra   = hp_q.vertex;
                    n_state = ST_POP_G;
                end
            end
            ST_POP_G: begin
                n_gu = cs_q;
                if (cs_q == COST_SENT) begin
                    n_state = ST_FIN_RD;
                end else begin
                    hp_re   = 1'b1;
                    hp_ra   = NODE_W'(r_cnt - CNT_W'(1));
                    n_state = ST_POP_L;
                end
            end
            ST_POP_L: begin
                // The popped node gets a position at the new count, which marks it closed.
                ps_we   = 1'b1;
                ps_wa   = r_u;
                ps_wd   = r_cnt - CNT_W'(1);
                n_cnt   = r_cnt - CNT_W'(1);
                n_ev    = hp_q.vertex;
                n_ek    = hp_q.key;
                n_i     = '0;
                n_state = ST_SD_L;
            end
            ST_SD_L: begin
                if (idx_l < r_cnt) begin
                    hp_re   = 1'b1;
                    hp_ra   = idx_l[NODE_W-1:0];
                    n_state = ST_SD_R;
                end else begin
                    n_state = ST_SD_FIN;
                end
            end
            ST_SD_R: begin
                n_lslot = hp_q;
                n_rok   = (idx_r < r_cnt);
                hp_re   = (idx_r < r_cnt);
                hp_ra   = idx_r[NODE_W-1:0];
                n_state = ST_SD_CMP;
            end
            ST_SD_CMP: begin
                case (sel)
                    2'd1: begin
                        hp_we   = 1'b1;
                        hp_wd   = r_lslot;
                        ps_we   = 1'b1;
                        ps_wa   = r_lslot.vertex;
                        n_i     = idx_l[NODE_W-1:0];
                        n_state = ST_SD_L;
                    end
                    2'd2: begin
                        hp_we   = 1'b1;
                        hp_wd   = hp_q;
                        ps_we   = 1'b1;
                        ps_wa   = hp_q.vertex;
                        n_i     = idx_r[NODE_W-1:0];
                        n_state = ST_SD_L;
                    end
                    default: n_state = ST_SD_FIN;
                endcase
            end
            ST_SD_FIN: begin
                hp_we   = 1'b1;
                ps_we   = 1'b1;
                hd_re   = 1'b1;
                hd_ra   = r_u;
                n_state = ST_ED_HEAD;
            end
            ST_ED_HEAD: begin
                n_link  = hd_q;
                n_state = ST_ED_CHK;
            end
            ST_ED_CHK: begin
                if (r_link != '0 && r_link <= r_ec) begin
                    eg_re   = 1'b1;
                    n_state = ST_ED_ARC;
                end else begin
                    n_state = ST_POP;
                end
            end
            ST_ED_ARC: begin
                n_w     = eg_q.target;
                n_link  = eg_q.next;
                n_cand  = CAND_W'(r_gu) + CAND_W'(eg_q.weight);
                ps_re   = 1'b1;
                ps_ra   = eg_q.target;
                n_state = (CNT_W'(eg_q.target) < r_nt) ? ST_ED_POS : ST_ED_CHK;
            end
            ST_ED_POS: begin
                n_pi = ps_q;
                if (ps_q < r_cnt && r_cand < CAND_W'(COST_SENT)) begin
                    cs_re   = 1'b1;
                    cs_ra   = r_w;
                    n_state = ST_ED_COST;
                end else begin
                    n_state = ST_ED_CHK;
                end
            end
            ST_ED_COST: begin
                if (r_cand < CAND_W'(cs_q)) begin
                    cs_we   = 1'b1;
                    cs_wa   = r_w;
                    cs_wd   = r_cand[COST_W-1:0];
                    crd_re  = 1'b1;
                    crd_ra  = r_w;
                    n_state = ST_ED_H1;
                end else begin
                    n_state = ST_ED_CHK;
                end
            end
            ST_ED_H1: n_state = ST_ED_H2;
            ST_ED_H2: begin
                n_ek    = KEY_W'(r_cand) + KEY_W'(oct_h);
                n_ev    = r_w;
                n_i     = r_pi[NODE_W-1:0];
                n_state = ST_SU;
            end
            ST_SU: begin
                if (r_i == '0) begin
                    n_state = ST_SU_FIN;
                end else begin
                    hp_re   = 1'b1;
                    hp_ra   = idx_p;
                    n_state = ST_SU_CMP;
                end
            end
            ST_SU_CMP: begin
                if (r_ek < hp_q.key) begin
                    hp_we   = 1'b1;
                    hp_wd   = hp_q;
                    ps_we   = 1'b1;
                    ps_wa   = hp_q.vertex;
                    n_i     = idx_p;
                    n_state = ST_SU;
                end else begin
                    n_state = ST_SU_FIN;
                end
            end
            ST_SU_FIN: begin
                hp_we   = 1'b1;
                ps_we   = 1'b1;
                n_state = ST_ED_CHK;
            end
            ST_FIN_RD: begin
                cs_re   = 1'b1;
                cs_ra   = r_req.goal_node;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_cost  = cs_q;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = '{path_cost: r_cost, reached: (r_cost < COST_SENT)};
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_POP_L |=> r_cnt == $past(r_cnt) - CNT_W'(1))
        else $error("heap count did not drop by one on extraction");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_CLEAR && r_state != ST_IDLE |-> r_cnt <= r_nt)
        else $error("heap count above node total");
    a_word_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_DONE))
        else $error("result word raised outside completion");
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ec <= LINK_W'(MAX_EDGES))
        else $error("edge count beyond capacity");
`endif

endmodule
`default_nettype wire

// ===== hdl/asp_ram.sv =====
`default_nettype none
module asp_ram #(
    parameter int DW = 32,
    parameter int AW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/asp_octile.sv =====
`default_nettype none
module asp_octile (
    input  wire logic           i_clk,
    input  wire asp_pkg::t_point i_a,
    input  wire asp_pkg::t_point i_b,
    output logic [asp_pkg::H_W-1:0] o_h
);
    import asp_pkg::*;

    logic [CRD_W-1:0] dx, dy, mn, mx;
    logic [H_W-1:0]   h;

    always_comb begin
        dx = (i_a.x > i_b.x) ? i_a.x - i_b.x : i_b.x - i_a.x;
        dy = (i_a.y > i_b.y) ? i_a.y - i_b.y : i_b.y - i_a.y;
        mn = (dx > dy) ? dy : dx;
        mx = (dx > dy) ? dx : dy;
        h  = H_W'(mn) * H_W'(DIAG_STEP) + H_W'(mx - mn) * H_W'(STRAIGHT_STEP);
    end

    always_ff @(posedge i_clk) begin
        o_h <= h;
    end

endmodule
`default_nettype wire
